// ===== rtl/apq_pkg.sv =====
// Shared types, codes and the ordering compare for the aging priority queue.
package apq_pkg;

   // Operation codes carried on the request tuser
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_TICK   = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // Result kinds carried on the response tuser
   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_REJECTED  = 3'd1,
      KIND_POPPED    = 3'd2,
      KIND_EMPTY     = 3'd3,
      KIND_EXPIRED   = 3'd4,
      KIND_TICK_DONE = 3'd5
   } kind_type;

   // Register index, taken from csr_paddr[2]
   localparam logic REG_THRESHOLD   = 1'b0;
   localparam logic REG_MAX_ENTRIES = 1'b1;

   localparam logic [11:0] THRESHOLD_RESET = 12'd20;
   localparam logic [4:0]  MAX_ENTRIES_RESET = 5'd16;

   // One queue entry, 48 bits
   typedef struct packed {
      logic [15:0] tag;
      logic [2:0]  prio;
      logic [11:0] stab;
      logic [15:0] arr;
      logic        crit;
   } entry_type;

   // One response word
   typedef struct packed {
      kind_type    kind;
      logic [15:0] tag;
      logic [2:0]  prio;
      logic [11:0] stab;
      logic [15:0] arr;
      logic        crit;
      logic        last;
   } rsp_word_type;

   // True when new entry n must be placed ahead of stored entry e
   function automatic logic goes_before(entry_type n, entry_type e);
      logic res;
      if (n.crit != e.crit) begin
         res = n.crit;
      end else if (n.prio != e.prio) begin
         res = (n.prio < e.prio);
      end else begin
         res = (n.arr < e.arr);
      end
      return res;
   endfunction

endpackage

// ===== rtl/apq_store.sv =====
// Entry store: single write port, single read port with registered read data.
module apq_store
   import apq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  entry_type                wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output entry_type                rdata
);

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data in the cycle after the address
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/aging_priority_queue_unit.sv =====
// Aging priority queue: sequencer over an entry store with one write and one read port.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | tdata: entry fields, tuser: op
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata: entry fields, tuser: kind, tlast
//  csr     | in        | APB, pready tied high   | threshold at 0x0, max entries at 0x4
//
// Every entry that moves is read, then written back one place over, and every
// compare during the placement scan reads its entry first. One word is worked
// at a time; req_tready is high only between words. Reset (synchronous)
// empties the queue at once, no clearing pass. A stalled response holds the
// sequencer at its next result; a finished result waits in the output
// register while a new word may be accepted.
module aging_priority_queue_unit
   import apq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata {arrival[46:31], prio_level[18:16] ... } see below
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // tag[15:0], prio_level[18:16], stability_in[30:19],
                                    // arrival[46:31], zero[47]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tag_out[15:0], prio_out[18:16], stability_out[30:19],
                                    // arrival_out[46:31], critical_out[47]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > 5) ? CW : 5;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_SCAN_CMP,
      S_SHR_RD,
      S_SHR_WR,
      S_SHL_RD,
      S_SHL_WR,
      S_POP_RD,
      S_TICK,
      S_TICK_CHK,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      JOB_INSERT,
      JOB_PROMOTE,
      JOB_POP,
      JOB_EXPIRE
   } job_type;

   state_type    state_ff, state_in;
   state_type    next_ff, next_in;
   job_type      job_ff, job_in;
   op_type       op_ff, op_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [11:0]  thr_ff, thr_in;
   logic [4:0]   max_ff, max_in;
   entry_type    new_ff, new_in;
   rsp_word_type res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [IW-1:0] ram_raddr;
   entry_type     ram_rdata;

   logic          out_free;
   logic          csr_write;
   logic [CW-1:0] jm1;
   logic [CW-1:0] jp1;
   entry_type     aged;

   apq_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign jm1       = j_ff - ONE_C;
   assign jp1       = j_ff + ONE_C;

   // entry read at the visit index, aged by one point
   always_comb begin
      aged = ram_rdata;
      aged.stab = ram_rdata.stab - 12'd1;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      job_in       = job_ff;
      op_in        = op_ff;
      occ_in       = occ_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      lim_in       = lim_ff;
      thr_in       = thr_ff;
      max_in       = max_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      ram_we       = 1'b0;
      ram_waddr    = j_ff[IW-1:0];
      ram_wdata    = new_ff;
      ram_raddr    = p_ff[IW-1:0];

      // register writes
      if (csr_write) begin
         if (csr_paddr[2] == REG_THRESHOLD) begin
            thr_in = csr_pwdata[11:0];
         end else begin
            max_in = csr_pwdata[4:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = op_type'(req_tuser);
               new_in.tag    = req_tdata[15:0];
               new_in.prio   = req_tdata[18:16];
               new_in.stab   = req_tdata[30:19];
               new_in.arr    = req_tdata[46:31];
               new_in.crit   = (req_tdata[30:19] <= thr_ff);
               state_in      = S_START;
            end
         end

         S_START: begin
            res_in      = '0;
            res_in.last = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  if ((MW'(occ_ff) >= MW'(max_ff)) || (occ_ff >= DEPTH_C)) begin
                     res_in.kind = KIND_REJECTED;
                     next_in     = S_IDLE;
                     state_in    = S_EMIT;
                  end else begin
                     job_in   = JOB_INSERT;
                     p_in     = '0;
                     lim_in   = occ_ff;
                     state_in = S_SCAN;
                  end
               end
               OP_TICK: begin
                  i_in     = '0;
                  state_in = S_TICK;
               end
               OP_POP: begin
                  if (occ_ff == '0) begin
                     res_in.kind = KIND_EMPTY;
                     next_in     = S_IDLE;
                     state_in    = S_EMIT;
                  end else begin
                     ram_raddr = '0;
                     state_in  = S_POP_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         // find the first entry the new one goes ahead of
         S_SCAN: begin
            ram_raddr = p_ff[IW-1:0];
            if (p_ff == lim_ff) begin
               j_in     = lim_ff;
               state_in = S_SHR_RD;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            if (goes_before(new_ff, ram_rdata)) begin
               j_in     = lim_ff;
               state_in = S_SHR_RD;
            end else begin
               p_in     = p_ff + ONE_C;
               state_in = S_SCAN;
            end
         end

         // open a gap at p by moving entries p..lim-1 up one place
         S_SHR_RD: begin
            ram_raddr = jm1[IW-1:0];
            if (j_ff == p_ff) begin
               ram_we    = 1'b1;
               ram_waddr = p_ff[IW-1:0];
               ram_wdata = new_ff;
               if (job_ff == JOB_INSERT) begin
                  occ_in      = occ_ff + ONE_C;
                  res_in      = '0;
                  res_in.kind = KIND_ACCEPTED;
                  res_in.last = 1'b1;
                  next_in     = S_IDLE;
                  state_in    = S_EMIT;
               end else begin
                  i_in     = i_ff + ONE_C;
                  state_in = S_TICK;
               end
            end else begin
               state_in = S_SHR_WR;
            end
         end

         S_SHR_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IW-1:0];
            ram_wdata = ram_rdata;
            j_in      = jm1;
            state_in  = S_SHR_RD;
         end

         // close the gap at j by moving the tail down one place
         S_SHL_RD: begin
            ram_raddr = jp1[IW-1:0];
            if (jp1 == occ_ff) begin
               occ_in = occ_ff - ONE_C;
               if (job_ff == JOB_POP) begin
                  next_in = S_IDLE;
               end else begin
                  next_in = S_TICK;
               end
               state_in = S_EMIT;
            end else begin
               state_in = S_SHL_WR;
            end
         end

         S_SHL_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IW-1:0];
            ram_wdata = ram_rdata;
            j_in      = jp1;
            state_in  = S_SHL_RD;
         end

         // head is in the read register
         S_POP_RD: begin
            res_in.kind = KIND_POPPED;
            res_in.tag  = ram_rdata.tag;
            res_in.prio = ram_rdata.prio;
            res_in.stab = ram_rdata.stab;
            res_in.arr  = ram_rdata.arr;
            res_in.crit = ram_rdata.crit;
            res_in.last = 1'b1;
            job_in      = JOB_POP;
            j_in        = '0;
            state_in    = S_SHL_RD;
         end

         // visit entries in queue order
         S_TICK: begin
            ram_raddr = i_ff[IW-1:0];
            if (i_ff == occ_ff) begin
               res_in      = '0;
               res_in.kind = KIND_TICK_DONE;
               res_in.last = 1'b1;
               next_in     = S_IDLE;
               state_in    = S_EMIT;
            end else begin
               state_in = S_TICK_CHK;
            end
         end

         S_TICK_CHK: begin
            if (ram_rdata.stab <= 12'd1) begin
               // expired: report and remove
               res_in      = '0;
               res_in.kind = KIND_EXPIRED;
               res_in.tag  = ram_rdata.tag;
               job_in      = JOB_EXPIRE;
               j_in        = i_ff;
               state_in    = S_SHL_RD;
            end else if (!ram_rdata.crit && (aged.stab <= thr_ff)) begin
               // newly critical: rotate into the critical group ahead of i
               new_in      = aged;
               new_in.crit = 1'b1;
               job_in      = JOB_PROMOTE;
               p_in        = '0;
               lim_in      = i_ff;
               state_in    = S_SCAN;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = i_ff[IW-1:0];
               ram_wdata = aged;
               i_in      = i_ff + ONE_C;
               state_in  = S_TICK;
            end
         end

         // hand the result to the output register
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = next_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         thr_ff       <= THRESHOLD_RESET;
         max_ff       <= MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         thr_ff       <= thr_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         next_ff      <= next_in;
         job_ff       <= job_in;
         op_ff        <= op_in;
         i_ff         <= i_in;
         p_ff         <= p_in;
         j_ff         <= j_in;
         lim_ff       <= lim_in;
         new_ff       <= new_in;
         res_ff       <= res_in;
         rsp_word_ff  <= rsp_word_in;
      end
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_word_ff.crit, rsp_word_ff.arr, rsp_word_ff.stab,
                        rsp_word_ff.prio, rsp_word_ff.tag};
   assign rsp_tuser  = rsp_word_ff.kind;
   assign rsp_tlast  = rsp_word_ff.last;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_ENTRIES) ? {27'd0, max_ff} : {20'd0, thr_ff};

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy above depth");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + ONE_C ||
                         occ_ff == $past(occ_ff) - ONE_C))
      else $error("occupancy moved by more than one");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SCAN_CMP) |-> (p_ff <= lim_ff && lim_ff <= occ_ff))
      else $error("placement scan beyond its limit");

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK) |-> (i_ff <= occ_ff))
      else $error("tick visit index beyond occupancy");

endmodule
